FILE: rtl/ceai_pkg.sv
// ceai_pkg: shared types for the complex element-wise integer ALU.
// Holds the operation codes and the control flags carried with each request.
// No dependencies.
package ceai_pkg;

    // Operation register codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam int OP_W = 2;

    // Control flags that travel with one request from front to back
    typedef struct packed {
        logic is_div;
        logic dz;
        logic last;
        logic neg_re;
        logic neg_im;
    } ctrl_t;

endpackage

FILE: rtl/ceai_front.sv
// ceai_front: accepts operand requests, forms products and sums, classifies.
// One register stage; output feeds the request queue.
// Depends on ceai_pkg.
module ceai_front import ceai_pkg::*; #(
    parameter int W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  op_t              op,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [W-1:0]     a_re,
    input  logic [W-1:0]     a_im,
    input  logic [W-1:0]     b_re,
    input  logic [W-1:0]     b_im,
    input  logic             last_in,
    output logic             push,
    input  logic             full,
    output ctrl_t            e_ctrl,
    output logic [W-1:0]     e_re,
    output logic [W-1:0]     e_im,
    output logic [2*W-1:0]   e_mag_re,
    output logic [2*W-1:0]   e_mag_im,
    output logic [2*W-1:0]   e_den
);
    localparam int PW = 2 * W;

    logic                 v_reg;
    op_t                  op_reg;
    logic                 last_reg;
    logic [W-1:0]         as_re_reg, as_im_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_r_reg, p_bb_i_reg;

    logic                 load;
    logic signed [PW:0]   nre, nim, den_sum;
    logic [PW-1:0]        mre_full, mim_full;

    assign in_ready = !v_reg || !full;
    assign load     = in_ready && in_valid;
    assign push     = v_reg && !full;

    // Valid flag of the product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    // Products and add/subtract results
    always_ff @(posedge aclk) begin
        if (load) begin
            op_reg     <= op;
            last_reg   <= last_in;
            as_re_reg  <= (op == OP_SUB) ? a_re - b_re : a_re + b_re;
            as_im_reg  <= (op == OP_SUB) ? a_im - b_im : a_im + b_im;
            p_rr_reg   <= PW'($signed(a_re) * $signed(b_re));
            p_ii_reg   <= PW'($signed(a_im) * $signed(b_im));
            p_ri_reg   <= PW'($signed(a_re) * $signed(b_im));
            p_ir_reg   <= PW'($signed(a_im) * $signed(b_re));
            p_bb_r_reg <= PW'($signed(b_re) * $signed(b_re));
            p_bb_i_reg <= PW'($signed(b_im) * $signed(b_im));
        end
    end

    // Classification and divider operands
    always_comb begin
        mre_full = p_rr_reg - p_ii_reg;
        mim_full = p_ri_reg + p_ir_reg;
        nre      = (PW+1)'(p_rr_reg) + (PW+1)'(p_ii_reg);
        nim      = (PW+1)'(p_ir_reg) - (PW+1)'(p_ri_reg);
        den_sum  = (PW+1)'(p_bb_r_reg) + (PW+1)'(p_bb_i_reg);
        e_den    = den_sum[PW-1:0];
        e_mag_re = nre[PW] ? PW'(-nre) : nre[PW-1:0];
        e_mag_im = nim[PW] ? PW'(-nim) : nim[PW-1:0];
        e_ctrl.is_div = (op_reg == OP_DIV);
        e_ctrl.dz     = (op_reg == OP_DIV) && (den_sum == '0);
        e_ctrl.last   = last_reg;
        e_ctrl.neg_re = nre[PW];
        e_ctrl.neg_im = nim[PW];
        e_re = (op_reg == OP_MUL) ? mre_full[W-1:0] : as_re_reg;
        e_im = (op_reg == OP_MUL) ? mim_full[W-1:0] : as_im_reg;
    end

endmodule

FILE: rtl/ceai_fifo.sv
// ceai_fifo: short request queue between front and back.
// Flop storage, read from the head without delay.
// No package dependencies.
module ceai_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] wdata,
    output logic          full,
    input  logic          pop,
    output logic [DW-1:0] rdata,
    output logic          empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn) !(pop && empty))
        else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

FILE: rtl/ceai_back.sv
// ceai_back: pipelined restoring divider plus output register.
// One quotient bit per stage for both components; other ops ride along.
// Depends on ceai_pkg.
module ceai_back import ceai_pkg::*; #(
    parameter int W = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           empty,
    output logic           pop,
    input  ctrl_t          h_ctrl,
    input  logic [W-1:0]   h_re,
    input  logic [W-1:0]   h_im,
    input  logic [2*W-1:0] h_mag_re,
    input  logic [2*W-1:0] h_mag_im,
    input  logic [2*W-1:0] h_den,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [W-1:0]   out_re,
    output logic [W-1:0]   out_im,
    output logic           out_last,
    output logic           out_dz
);
    localparam int NB = 2 * W;

    logic          v_reg   [NB+1];
    ctrl_t         c_reg   [NB+1];
    logic [W-1:0]  re_reg  [NB+1];
    logic [W-1:0]  im_reg  [NB+1];
    logic [NB-1:0] den_reg [NB+1];
    logic [2*NB-1:0] rq_re_reg [NB+1];
    logic [2*NB-1:0] rq_im_reg [NB+1];

    logic          ovalid_reg, olast_reg, odz_reg;
    logic [W-1:0]  ore_reg, oim_reg;
    logic          adv;
    logic [W-1:0]  q_re, q_im;

    assign adv = !(ovalid_reg && !out_ready);
    assign pop = adv && !empty;

    // Stage 0: take the queue head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= !empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_reg[0]     <= h_ctrl;
            re_reg[0]    <= h_re;
            im_reg[0]    <= h_im;
            den_reg[0]   <= h_den;
            rq_re_reg[0] <= {{NB{1'b0}}, h_mag_re};
            rq_im_reg[0] <= {{NB{1'b0}}, h_mag_im};
        end
    end

    // Divider stages: one restoring step each
    for (genvar k = 0; k < NB; k++) begin : g_step
        logic [NB:0]   top_re, top_im, dsub_re, dsub_im;
        logic          ge_re, ge_im;
        logic [NB-1:0] rem_re, rem_im;

        always_comb begin
            top_re  = rq_re_reg[k][2*NB-1:NB-1];
            top_im  = rq_im_reg[k][2*NB-1:NB-1];
            dsub_re = top_re - {1'b0, den_reg[k]};
            dsub_im = top_im - {1'b0, den_reg[k]};
            ge_re   = !dsub_re[NB];
            ge_im   = !dsub_im[NB];
            rem_re  = ge_re ? dsub_re[NB-1:0] : top_re[NB-1:0];
            rem_im  = ge_im ? dsub_im[NB-1:0] : top_im[NB-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (adv) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                c_reg[k+1]     <= c_reg[k];
                re_reg[k+1]    <= re_reg[k];
                im_reg[k+1]    <= im_reg[k];
                den_reg[k+1]   <= den_reg[k];
                rq_re_reg[k+1] <= {rem_re, rq_re_reg[k][NB-2:0], ge_re};
                rq_im_reg[k+1] <= {rem_im, rq_im_reg[k][NB-2:0], ge_im};
            end
        end
    end

    // Quotient sign fix-up
    assign q_re = c_reg[NB].neg_re ? W'(-rq_re_reg[NB][W-1:0]) : rq_re_reg[NB][W-1:0];
    assign q_im = c_reg[NB].neg_im ? W'(-rq_im_reg[NB][W-1:0]) : rq_im_reg[NB][W-1:0];

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (adv) begin
            ovalid_reg <= v_reg[NB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            olast_reg <= c_reg[NB].last;
            odz_reg   <= c_reg[NB].dz;
            if (c_reg[NB].dz) begin
                ore_reg <= '0;
                oim_reg <= '0;
            end else if (c_reg[NB].is_div) begin
                ore_reg <= q_re;
                oim_reg <= q_im;
            end else begin
                ore_reg <= re_reg[NB];
                oim_reg <= im_reg[NB];
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_re    = ore_reg;
    assign out_im    = oim_reg;
    assign out_last  = olast_reg;
    assign out_dz    = odz_reg;

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && odz_reg) |-> (ore_reg == '0 && oim_reg == '0))
        else $error("zero divisor result not cleared");
    a_dz_div_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[NB] && c_reg[NB].dz) |-> c_reg[NB].is_div)
        else $error("zero divisor flag outside divide");

endmodule

FILE: rtl/complex_elementwise_alu_int_core.sv
// complex_elementwise_alu_int_core: element-wise complex add/sub/mul/div.
// Use: stream operand pairs on s_*, read results on m_*. cfg_wr_en writes the
// operation (0 add, 1 subtract, 2 multiply, 3 divide); the user writes it only
// while the block is idle, which the block itself does not enforce. s_tdata
// holds a_re, a_im, b_re, b_im; m_tdata holds out_re, out_im; m_tuser is the
// divide-by-zero flag; tlast passes through unchanged.
// Throughput: one request per cycle unless m_tready stalls, set by the fully
// pipelined divider (2*DATA_WIDTH restoring stages, one quotient bit per stage).
// Path to m_tvalid: product stage, queue storage, queue head stage, divider
// stages, output register; every operation takes the same path, so order is kept.
// A four-entry queue separates the front (multipliers) from the divider; when
// m_tready is low the divider and output hold, the queue fills, and then
// s_tready drops. Reset clears all valid flags and sets the operation to add.
// Depends on ceai_pkg, ceai_front, ceai_fifo, ceai_back.
module complex_elementwise_alu_int_core import ceai_pkg::*; #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [OP_W-1:0]        cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,  // a_re, a_im, b_re, b_im
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,  // out_re, out_im
    output logic                   m_tuser,              // divide_by_zero
    output logic                   m_tlast
);
    localparam int W    = DATA_WIDTH;
    localparam int MDW  = ((2*DATA_WIDTH+7)/8)*8;
    localparam int QW   = 2*W + 3*2*W + $bits(ctrl_t);

    op_t           op_reg;
    logic          push, full, pop, empty;
    ctrl_t         f_ctrl, h_ctrl;
    logic [W-1:0]  f_re, f_im, h_re, h_im, o_re, o_im;
    logic [2*W-1:0] f_mag_re, f_mag_im, f_den, h_mag_re, h_mag_im, h_den;
    logic [QW-1:0] q_wdata, q_rdata;

    // Operation register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_ADD;
        end else if (cfg_wr_en) begin
            op_reg <= op_t'(cfg_wr_data);
        end
    end

    ceai_front #(.W(W)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .a_re     (s_tdata[W-1:0]),
        .a_im     (s_tdata[2*W-1:W]),
        .b_re     (s_tdata[3*W-1:2*W]),
        .b_im     (s_tdata[4*W-1:3*W]),
        .last_in  (s_tlast),
        .push     (push),
        .full     (full),
        .e_ctrl   (f_ctrl),
        .e_re     (f_re),
        .e_im     (f_im),
        .e_mag_re (f_mag_re),
        .e_mag_im (f_mag_im),
        .e_den    (f_den)
    );

    assign q_wdata = {f_ctrl, f_re, f_im, f_mag_re, f_mag_im, f_den};
    assign {h_ctrl, h_re, h_im, h_mag_re, h_mag_im, h_den} = q_rdata;

    ceai_fifo #(.DW(QW), .DEPTH(4)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (q_wdata),
        .full    (full),
        .pop     (pop),
        .rdata   (q_rdata),
        .empty   (empty)
    );

    ceai_back #(.W(W)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .pop       (pop),
        .h_ctrl    (h_ctrl),
        .h_re      (h_re),
        .h_im      (h_im),
        .h_mag_re  (h_mag_re),
        .h_mag_im  (h_mag_im),
        .h_den     (h_den),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_re    (o_re),
        .out_im    (o_im),
        .out_last  (m_tlast),
        .out_dz    (m_tuser)
    );

    assign m_tdata = MDW'({o_im, o_re});

endmodule

FILE: bench/complex_elementwise_alu_int_core_chk.sv
// Result checker for the complex element-wise integer ALU.
// Watches both stream channels, predicts each result and compares it.
// Depends on ceai_pkg.
`timescale 1ns / 100ps

module complex_elementwise_alu_int_core_chk import ceai_pkg::*; #(
    parameter int DW = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  op_t                               op_mode,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [((4*DW+7)/8)*8-1:0]         s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [((2*DW+7)/8)*8-1:0]         m_tdata,
    input  logic                              m_tuser,
    input  logic                              m_tlast,
    output int                                err_count,
    output int                                pending,
    output logic                              accept_seen
);

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          last;
        logic          dz;
    } cplx_res_t;

    cplx_res_t result_q[$];

    // Exact quotient truncated toward zero
    function automatic logic signed [DW-1:0] trunc_div(longint num, longint den);
        longint q;
        q = num / den;
        return q[DW-1:0];
    endfunction

    function automatic cplx_res_t alu_predict(op_t op, logic [4*DW-1:0] d, logic lst);
        longint ar, ai, br, bi, den, r, i;
        cplx_res_t res;
        ar = $signed(d[DW-1:0]);
        ai = $signed(d[2*DW-1:DW]);
        br = $signed(d[3*DW-1:2*DW]);
        bi = $signed(d[4*DW-1:3*DW]);
        r = 0;
        i = 0;
        res.dz = 1'b0;
        case (op)
            OP_ADD: begin r = ar + br; i = ai + bi; end
            OP_SUB: begin r = ar - br; i = ai - bi; end
            OP_MUL: begin r = ar*br - ai*bi; i = ar*bi + ai*br; end
            default: begin
                den = br*br + bi*bi;
                if (den == 0) begin
                    res.dz = 1'b1;
                end else begin
                    r = trunc_div(ar*br + ai*bi, den);
                    i = trunc_div(ai*br - ar*bi, den);
                end
            end
        endcase
        res.re = r[DW-1:0];
        res.im = i[DW-1:0];
        res.last = lst;
        return res;
    endfunction

    assign pending = result_q.size();

    always @(posedge aclk) begin
        cplx_res_t exp_r, got;
        if (!aresetn) begin
            err_count   <= 0;
            accept_seen <= 1'b0;
        end else begin
            accept_seen <= (s_tvalid && s_tready) || (m_tvalid && m_tready);
            // predict on each accepted request
            if (s_tvalid && s_tready) begin
                result_q.push_back(alu_predict(op_mode, s_tdata[4*DW-1:0], s_tlast));
            end
            // compare each accepted result against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[DW-1:0], m_tdata[2*DW-1:DW], m_tlast, m_tuser};
                if (result_q.size() == 0) begin
                    if (err_count < 10) $display("ERROR: unexpected result %h", got);
                    err_count <= err_count + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    if (got !== exp_r) begin
                        if (err_count < 10)
                            $display("ERROR: re/im/last/dz exp %h %h %b %b got %h %h %b %b",
                                exp_r.re, exp_r.im, exp_r.last, exp_r.dz,
                                got.re, got.im, got.last, got.dz);
                        err_count <= err_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: bench/complex_elementwise_alu_int_core_tb.sv
// Testbench top for the complex element-wise integer ALU.
// Drives operand requests and operation settings, gives the verdict.
// Depends on ceai_pkg, complex_elementwise_alu_int_core, the checker.
`timescale 1ns / 100ps

module complex_elementwise_alu_int_core_tb;
    import ceai_pkg::*;

    localparam int DW = 16;
    localparam int LATENCY = 2*DW + 3;
    localparam int WDOG_LIMIT = 5000;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [OP_W-1:0] cfg_wr_data;
    logic s_tvalid, s_tready, s_tlast;
    logic [((4*DW+7)/8)*8-1:0] s_tdata;   // a_re, a_im, b_re, b_im
    logic m_tvalid, m_tready, m_tlast;
    logic [((2*DW+7)/8)*8-1:0] m_tdata;   // out_re, out_im
    logic m_tuser;                        // divide_by_zero
    op_t op_mode;
    int err_count, pending, idle_cycles;
    logic accept_seen;
    logic hold_off;

    complex_elementwise_alu_int_core #(.DATA_WIDTH(DW)) u_top (.*);

    complex_elementwise_alu_int_core_chk #(.DW(DW)) u_chk (
        .aclk, .aresetn, .op_mode, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .err_count, .pending, .accept_seen
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver stall pattern, with a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
    end

    // Watchdog on cycles with no accepted request or result
    always @(posedge aclk) begin
        if (!aresetn || accept_seen || hold_off) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [DW-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(DW-1){1'b0}}};
            1: return {1'b0, {(DW-1){1'b1}}};
            2: return '0;
            3: return DW'($urandom_range(0, 4)) - DW'(2);
            default: return DW'($urandom);
        endcase
    endfunction

    // Send one operand request and wait for acceptance
    task automatic send_pair(logic [DW-1:0] ar, ai, br, bi, logic lst);
        s_tdata  <= {br[DW-1:0] == 0 ? bi : bi, br, ai, ar};
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
    endtask

    // Drain results, let the pipe settle, then write the operation
    task automatic set_operation(op_t op);
        drop_valid();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= op;
        op_mode     <= op;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_burst(int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_pair(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                          $urandom_range(0, 7) == 0);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                drop_valid();
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE  = DW'(1);

    initial begin
        op_t ops[4];
        ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        aresetn = 1'b0; hold_off = 1'b0;
        cfg_wr_en = 1'b0; cfg_wr_data = OP_ADD; op_mode = OP_ADD;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes under every operation, zero divisor
        foreach (ops[j]) begin
            set_operation(ops[j]);
            send_pair(MAXV, MAXV, MAXV, MAXV, 1'b0);
            send_pair(MINV, MINV, MINV, MINV, 1'b1);
            send_pair(MAXV, MINV, MINV, MAXV, 1'b0);
            send_pair(ONE, '0, '0, '0, 1'b1);
            send_pair(MINV, MINV, ONE, '0, 1'b0);
            send_pair(MINV, '1, '1, '0, 1'b1);
        end

        // Long receiver hold-off while the sender keeps offering
        set_operation(OP_MUL);
        fork
            begin
                hold_off <= 1'b1;
                repeat (200) @(posedge aclk);
                hold_off <= 1'b0;
            end
            random_burst(60);
        join

        // Random phases across all operations
        for (int p = 0; p < 8; p++) begin
            set_operation(ops[$urandom_range(0, 3)]);
            random_burst(90);
        end
        set_operation(OP_DIV);
        random_burst(40);
        set_operation(OP_ADD);

        drop_valid();
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ceai_pkg.sv
rtl/ceai_front.sv
rtl/ceai_fifo.sv
rtl/ceai_back.sv
rtl/complex_elementwise_alu_int_core.sv
bench/complex_elementwise_alu_int_core_chk.sv
bench/complex_elementwise_alu_int_core_tb.sv
